FILE: hdl/lzo1z_decompressor_core_assert.svh
// assertion macros used by the lzo1z decoder core
`ifndef LZO1Z_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZO1Z_DECOMPRESSOR_CORE_ASSERT_SVH

// check that a condition implies a consequence in the same cycle
`define LZD_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// check that a condition implies a consequence in the next cycle
`define LZD_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// shared types and constants of the lzo1z stream decoder
// ----------------------------------------------------------------------------
package lzd_pkg;

   localparam int WINDOW_BYTES_DEF = 65536;
   localparam int COUNT_BITS_DEF   = 24;
   localparam int CFG_BITS         = 24;
   localparam int DIST_BITS        = 16;

   // commands
   localparam logic [1:0] CMD_FEED    = 2'd0;
   localparam logic [1:0] CMD_PULL    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // status codes
   localparam logic [2:0] ST_READY  = 3'd0;
   localparam logic [2:0] ST_COPY   = 3'd1;
   localparam logic [2:0] ST_DONE   = 3'd2;
   localparam logic [2:0] ST_TRUNC  = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_DIST   = 3'd5;
   localparam logic [2:0] ST_MISUSE = 3'd6;

   // format constants
   localparam logic [7:0]  FIRST_BIAS    = 8'd17;
   localparam logic [15:0] M1_AFTER_LIT  = 16'h0700;
   localparam logic [15:0] M4_BASE       = 16'h4000;
   localparam logic [4:0]  M2_REUSE_CODE = 5'h1c;

   typedef enum logic [3:0] {
      PH_FIRST, PH_OP, PH_OP_AFTER_LIT, PH_MATCH_OP, PH_LIT_EXT, PH_LIT_COPY,
      PH_TRAIL_COPY, PH_SHORT_OFF, PH_MATCH_EXT, PH_OFF0, PH_OFF1, PH_COPY,
      PH_DONE, PH_TRUNC, PH_FULL, PH_DIST
   } phase_type;

   // write request from the decoder to the history memory
   typedef struct packed {
      logic       en;
      logic [7:0] data;
   } hist_wr_type;

   function automatic logic [2:0] phase_status(input phase_type p);
      case (p)
         PH_COPY:  phase_status = ST_COPY;
         PH_DONE:  phase_status = ST_DONE;
         PH_TRUNC: phase_status = ST_TRUNC;
         PH_FULL:  phase_status = ST_FULL;
         PH_DIST:  phase_status = ST_DIST;
         default:  phase_status = ST_READY;
      endcase
   endfunction

endpackage

FILE: hdl/lzd_history.sv
// ----------------------------------------------------------------------------
// lzd_history
// history window memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lzd_history #(
   parameter int WINDOW_BYTES = lzd_pkg::WINDOW_BYTES_DEF,
   parameter int ADDR_BITS    = $clog2(WINDOW_BYTES)
) (
   input  logic                 clock,
   input  lzd_pkg::hist_wr_type wr,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [7:0]           rd_data
);
   import lzd_pkg::*;

   logic [7:0] mem [WINDOW_BYTES];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr.data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: hdl/lzo1z_decompressor_core.sv
// lzo1z stream decoder, one command per req transfer
// the rsp is registered from the req transfer; the rsp register and skid
//   stage let a new req transfer follow every cycle, one item per cycle, while skid is empty
// match bytes are prefetched from the history memory at the next state's address; a byte
//   written the cycle before is forwarded around the memory
// reset: synchronous, clears control state; history stays undefined
// ----------------------------------------------------------------------------
// lzo1z_decompressor_core
// decodes lzo1z literal runs and m1..m4 matches into a byte stream
// ----------------------------------------------------------------------------
module lzo1z_decompressor_core #(
   parameter int WINDOW_BYTES = lzd_pkg::WINDOW_BYTES_DEF,
   parameter int COUNT_BITS   = lzd_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // command[1:0], in_byte[9:2], zero fill
   input  logic        req_tlast,   // in_last
   // responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_byte[7:0], status[10:8],
                                    // total_length[34:11], zero fill
   output logic        rsp_tuser    // out_valid
);
   import lzd_pkg::*;

   localparam int ABITS = $clog2(WINDOW_BYTES);
   localparam int CW    = COUNT_BITS + 1;
   localparam logic [CW-1:0] CMASK = {1'b0, {COUNT_BITS{1'b1}}};

   // ---------------- state
   phase_type            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] wcnt_ff, wcnt_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [15:0]          pdist_ff, pdist_in;
   logic [15:0]          cdist_ff, cdist_in;
   logic [7:0]           held_ff, held_in;
   logic [1:0]           trail_ff, trail_in;
   logic                 far_ff, far_in;
   logic [23:0]          maxb_ff;
   logic [COUNT_BITS-1:0] cap;

   // ---------------- output register with skid stage
   logic        ov_ff, sv_ff;
   logic [35:0] od_ff, sd_ff;
   logic [35:0] rsp_word;
   logic [23:0] total_in;

   logic acc;
   assign req_tready = !sv_ff;
   assign csr_ready  = 1'b1;
   assign acc = req_tvalid && req_tready;

   logic [1:0] cmd;
   logic [7:0] b;
   assign cmd = req_tdata[1:0];
   assign b   = req_tdata[9:2];

   // capacity is the smaller of the register and the counter range
   always_comb begin
      if (COUNT_BITS >= CFG_BITS) cap = COUNT_BITS'(maxb_ff);
      else if ((maxb_ff >> COUNT_BITS) != '0) cap = '1;
      else cap = COUNT_BITS'(maxb_ff);
   end

   // ---------------- history memory with forwarding
   hist_wr_type          hwr;
   logic [ABITS-1:0]     rd_addr, wr_addr;
   logic [7:0]           rd_data;
   logic                 fwd_ff;
   logic [7:0]           fwd_data_ff;
   logic [7:0]           hist_byte;
   logic [COUNT_BITS-1:0] src_now, src_next;

   assign wr_addr = ABITS'(wcnt_ff % WINDOW_BYTES);

   lzd_history #(.WINDOW_BYTES(WINDOW_BYTES), .ADDR_BITS(ABITS)) u_hist (
      .clock  (clock),
      .wr     (hwr),
      .wr_addr(wr_addr),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // prefetch address for the next pull: next write count minus next distance
   assign src_next = wcnt_in - COUNT_BITS'(cdist_in);
   assign rd_addr  = ABITS'(src_next % WINDOW_BYTES);
   assign src_now  = wcnt_ff - COUNT_BITS'(cdist_ff);

   // a source equal to the byte written last cycle comes from the bypass
   always_ff @(posedge clock) begin
      fwd_ff      <= hwr.en && (rd_addr == wr_addr);
      fwd_data_ff <= hwr.data;
   end
   assign hist_byte = fwd_ff ? fwd_data_ff : rd_data;

   // ---------------- decode helpers
   function automatic logic too_long(input logic [COUNT_BITS-1:0] w,
                                     input logic [CW-1:0] n,
                                     input logic [COUNT_BITS-1:0] c);
      logic [CW:0] s;
      s = {1'b0, w} + {1'b0, n};
      too_long = s > {2'b0, c};
   endfunction

   logic [2:0] st;
   logic       ovalid;
   logic [7:0] obyte;
   logic [CW-1:0] n_lit;
   logic [CW-1:0] grow;
   logic [15:0] off_dist;
   logic [13:0] off;
   logic        do_match, do_lit;
   logic [CW-1:0] m_len;
   logic [15:0]   m_dist;
   logic          lit_ok;
   phase_type     lit_next;

   // next state of the decoder
   always_comb begin
      phase_in = phase_ff;
      wcnt_in  = wcnt_ff;
      rem_in   = rem_ff;
      pdist_in = pdist_ff;
      cdist_in = cdist_ff;
      held_in  = held_ff;
      trail_in = trail_ff;
      far_in   = far_ff;
      hwr.en   = 1'b0;
      hwr.data = b;
      ovalid   = 1'b0;
      obyte    = 8'd0;
      st       = ST_READY;
      n_lit    = '0;
      grow     = '0;
      off_dist = '0;
      off      = '0;
      do_match = 1'b0;
      do_lit   = 1'b0;
      m_len    = '0;
      m_dist   = '0;
      lit_next = PH_LIT_COPY;
      lit_ok   = 1'b0;
      if (acc) begin
         if (cmd == CMD_RESTART) begin
            phase_in = PH_FIRST;
            wcnt_in  = '0;
            rem_in   = '0;
            pdist_in = '0;
            cdist_in = '0;
            held_in  = '0;
            trail_in = '0;
            far_in   = 1'b0;
         end else if (phase_ff inside {PH_DONE, PH_TRUNC, PH_FULL, PH_DIST}) begin
            // final state holds
         end else if (cmd == CMD_PULL && phase_ff == PH_COPY) begin
            hwr.en   = 1'b1;
            hwr.data = hist_byte;
            ovalid   = 1'b1;
            obyte    = hist_byte;
            wcnt_in  = wcnt_ff + 1'b1;
            rem_in   = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
            if (rem_in == '0) begin
               if (trail_ff != 2'd0) begin
                  do_lit   = 1'b1;
                  n_lit    = CW'(trail_ff);
                  lit_next = PH_TRAIL_COPY;
               end else begin
                  phase_in = PH_OP;
               end
            end
         end else if (cmd == CMD_FEED && phase_ff != PH_COPY) begin
            // opcode decode shared by the opcode phases
            case (phase_ff)
               PH_FIRST, PH_OP, PH_OP_AFTER_LIT, PH_MATCH_OP: begin
                  if (phase_ff == PH_FIRST && b > FIRST_BIAS) begin
                     do_lit   = 1'b1;
                     n_lit    = CW'(b - FIRST_BIAS);
                     lit_next = (b - FIRST_BIAS < 8'd4) ? PH_TRAIL_COPY : PH_LIT_COPY;
                  end else if (b >= 8'd64) begin
                     if (b[4:0] >= M2_REUSE_CODE) begin
                        trail_in = b[1:0];
                        do_match = 1'b1;
                        m_dist   = pdist_ff;
                        m_len    = CW'(b[7:5]) + 1'b1;
                     end else begin
                        cdist_in = 16'd1 + {5'd0, b[4:0], 6'd0};
                        rem_in   = COUNT_BITS'(b[7:5]) + 1'b1;
                        phase_in = PH_SHORT_OFF;
                     end
                  end else if (b >= 8'd32) begin
                     cdist_in = 16'd1;
                     far_in   = 1'b0;
                     if (b[4:0] == 5'd0) begin
                        rem_in = COUNT_BITS'(31); phase_in = PH_MATCH_EXT;
                     end else begin
                        rem_in = COUNT_BITS'(b[4:0]) + 2'd2; phase_in = PH_OFF0;
                     end
                  end else if (b >= 8'd16) begin
                     far_in   = b[3];
                     cdist_in = b[3] ? 16'h8000 : M4_BASE;
                     if (b[2:0] == 3'd0) begin
                        rem_in = COUNT_BITS'(7); phase_in = PH_MATCH_EXT;
                     end else begin
                        rem_in = COUNT_BITS'(b[2:0]) + 2'd2; phase_in = PH_OFF0;
                     end
                  end else if (phase_ff == PH_OP_AFTER_LIT) begin
                     cdist_in = M1_AFTER_LIT + 16'd1 + {6'd0, b[3:0], 6'd0};
                     rem_in   = COUNT_BITS'(3);
                     phase_in = PH_SHORT_OFF;
                  end else if (phase_ff == PH_MATCH_OP) begin
                     cdist_in = 16'd1 + {6'd0, b[3:0], 6'd0};
                     rem_in   = COUNT_BITS'(2);
                     phase_in = PH_SHORT_OFF;
                  end else if (b == 8'd0) begin
                     rem_in   = COUNT_BITS'(15);
                     phase_in = PH_LIT_EXT;
                  end else begin
                     do_lit = 1'b1;
                     n_lit  = CW'(b) + 2'd3;
                  end
               end
               PH_LIT_EXT: begin
                  if (b == 8'd0) begin
                     grow = {1'b0, rem_ff} + CW'(255);
                     if ((grow & ~CMASK) != '0) phase_in = PH_FULL;
                     else rem_in = COUNT_BITS'(grow);
                  end else begin
                     do_lit = 1'b1;
                     n_lit  = {1'b0, rem_ff} + CW'(b) + 2'd3;
                  end
               end
               PH_LIT_COPY, PH_TRAIL_COPY: begin
                  hwr.en  = 1'b1;
                  ovalid  = 1'b1;
                  obyte   = b;
                  wcnt_in = wcnt_ff + 1'b1;
                  rem_in  = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
                  if (rem_in == '0)
                     phase_in = (phase_ff == PH_LIT_COPY) ? PH_OP_AFTER_LIT : PH_MATCH_OP;
               end
               PH_SHORT_OFF: begin
                  off_dist = cdist_ff + {10'd0, b[7:2]};
                  pdist_in = off_dist;
                  trail_in = b[1:0];
                  do_match = 1'b1;
                  m_dist   = off_dist;
                  m_len    = {1'b0, rem_ff};
               end
               PH_MATCH_EXT: begin
                  grow = {1'b0, rem_ff} + ((b == 8'd0) ? CW'(255) : CW'(b) + 2'd2);
                  if ((grow & ~CMASK) != '0) phase_in = PH_FULL;
                  else begin
                     rem_in = COUNT_BITS'(grow);
                     if (b != 8'd0) phase_in = PH_OFF0;
                  end
               end
               PH_OFF0: begin
                  held_in  = b;
                  phase_in = PH_OFF1;
               end
               PH_OFF1: begin
                  off      = {held_ff, b[7:2]};
                  trail_in = b[1:0];
                  if (cdist_ff == 16'd1) begin
                     off_dist = 16'd1 + {2'd0, off};
                  end else begin
                     off_dist = cdist_ff + {2'd0, off};
                  end
                  if (cdist_ff != 16'd1 && !far_ff && off == '0) begin
                     phase_in = PH_DONE;
                  end else begin
                     pdist_in = off_dist;
                     do_match = 1'b1;
                     m_dist   = off_dist;
                     m_len    = {1'b0, rem_ff};
                  end
               end
               default: ;
            endcase
         end
         // literal run start with capacity check against the updated count
         if (do_lit) begin
            lit_ok = ((n_lit & ~CMASK) == '0) && !too_long(wcnt_in, n_lit, cap);
            if (!lit_ok) phase_in = PH_FULL;
            else begin
               rem_in   = COUNT_BITS'(n_lit);
               phase_in = lit_next;
            end
         end
         // match start: distance check before capacity
         if (do_match) begin
            if (m_dist == '0 || COUNT_BITS'(m_dist) > wcnt_ff
                || (COUNT_BITS < DIST_BITS && (m_dist >> COUNT_BITS) != '0))
               phase_in = PH_DIST;
            else if (too_long(wcnt_ff, m_len, cap)) phase_in = PH_FULL;
            else begin
               cdist_in = m_dist;
               rem_in   = COUNT_BITS'(m_len);
               phase_in = PH_COPY;
            end
         end
         // truncation and status
         if (cmd == CMD_FEED && phase_ff != PH_COPY
             && !(phase_ff inside {PH_DONE, PH_TRUNC, PH_FULL, PH_DIST})) begin
            if (req_tlast && !(phase_in inside {PH_DONE, PH_TRUNC, PH_FULL, PH_DIST}))
               phase_in = PH_TRUNC;
            st = phase_status(phase_in);
         end else if (cmd == CMD_RESTART
                      || phase_ff inside {PH_DONE, PH_TRUNC, PH_FULL, PH_DIST}
                      || (cmd == CMD_PULL && phase_ff == PH_COPY)) begin
            st = phase_status(phase_in);
         end else begin
            st = ST_MISUSE;
         end
      end
   end

   assign total_in = 24'(wcnt_in);
   assign rsp_word = {total_in, st, ovalid, obyte};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         wcnt_ff  <= '0;
         rem_ff   <= '0;
         pdist_ff <= '0;
         cdist_ff <= '0;
         held_ff  <= '0;
         trail_ff <= '0;
         far_ff   <= 1'b0;
         maxb_ff  <= '1;
      end else begin
         phase_ff <= phase_in;
         wcnt_ff  <= wcnt_in;
         rem_ff   <= rem_in;
         pdist_ff <= pdist_in;
         cdist_ff <= cdist_in;
         held_ff  <= held_in;
         trail_ff <= trail_in;
         far_ff   <= far_in;
         if (csr_valid && csr_ready) maxb_ff <= csr_data;
      end
   end

   // response register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         if (!ov_ff || rsp_tready) begin
            if (sv_ff) begin
               ov_ff <= 1'b1;
               od_ff <= sd_ff;
               sv_ff <= 1'b0;
            end else begin
               ov_ff <= acc;
               if (acc) od_ff <= rsp_word;
            end
            if (sv_ff && acc) begin
               sv_ff <= 1'b1;
               sd_ff <= rsp_word;
            end
         end else if (acc) begin
            sv_ff <= 1'b1;
            sd_ff <= rsp_word;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = od_ff[8];
   assign rsp_tdata  = {5'd0, od_ff[35:9], od_ff[7:0]};

   `include "lzo1z_decompressor_core_assert.svh"

   `LZD_ASSERT_IMP(a_skid_full_stall, clock, reset, sv_ff, ov_ff && !req_tready, "skid without output")
   `LZD_ASSERT_IMP(a_copy_src, clock, reset, phase_ff == PH_COPY, cdist_ff != '0, "zero copy distance")
   `LZD_ASSERT_NEXT(a_final_holds, clock, reset, (phase_ff == PH_DONE) && !(acc && cmd == CMD_RESTART), phase_ff == PH_DONE, "done state left")
   `LZD_ASSERT_IMP(a_pull_src, clock, reset, hwr.en && phase_ff == PH_COPY, src_now != wcnt_ff, "copy reads own slot")
endmodule
